// ===== rtl/h2sfp_pkg.sv =====
package h2sfp_pkg;

  localparam int unsigned HdrBytes    = 9;
  localparam int unsigned EntryBytes  = 6;
  localparam int unsigned NumSettings = 6;

  typedef enum logic [1:0] {
    StatusApplied   = 2'd0,
    StatusAckIgnored = 2'd1,
    StatusBadLength = 2'd2
  } status_e;

  typedef logic [NumSettings-1:0][31:0] setting_vec_t;

  // Protocol initial values, index 0 is identifier 1.
  localparam setting_vec_t InitSettings = {
    32'hFFFF_FFFF,  // max header list size
    32'd16384,      // max frame size
    32'd65535,      // initial window size
    32'hFFFF_FFFF,  // max concurrent streams
    32'd1,          // enable push
    32'd4096        // header table size
  };

  typedef struct packed {
    logic    emit;
    status_e status;
  } parse_res_t;

  // Remainder by six for values up to 275, using a reciprocal multiply.
  function automatic logic [2:0] mod6(input logic [8:0] x);
    logic [17:0] prod;
    logic [8:0]  q;
    logic [8:0]  r;
    prod = 18'(x) * 18'd171;
    q    = 9'(prod[17:10]);
    r    = x - (q << 2) - (q << 1);
    return r[2:0];
  endfunction

endpackage

// ===== rtl/h2sfp_if.sv =====
interface h2sfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_start;

  modport source (output valid, output frame_byte, output frame_start, input ready);
  modport sink   (input valid, input frame_byte, input frame_start, output ready);
endinterface

interface h2sfp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_status;
  logic [31:0] table_size;
  logic [31:0] push_enable;
  logic [31:0] stream_limit;
  logic [31:0] window_size;
  logic [31:0] frame_limit;
  logic [31:0] hdr_list_limit;

  modport source (
    output valid, output frame_status, output table_size, output push_enable,
    output stream_limit, output window_size, output frame_limit,
    output hdr_list_limit, input ready
  );
  modport sink (
    input valid, input frame_status, input table_size, input push_enable,
    input stream_limit, input window_size, input frame_limit,
    input hdr_list_limit, output ready
  );
endinterface

// ===== rtl/h2sfp_parse.sv =====
module h2sfp_parse (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic                    step_i,
  input  logic [7:0]              byte_i,
  input  logic                    start_i,
  output h2sfp_pkg::parse_res_t   res_o,
  output h2sfp_pkg::setting_vec_t settings_o
);

  localparam int unsigned HdrLast = h2sfp_pkg::HdrBytes - 1;

  logic [24:0] pos_q, pos_d;
  logic [23:0] len_q, len_d;
  logic [2:0]  mod_q, mod_d;
  logic [47:0] shift_q, shift_d;
  logic [2:0]  idx_q, idx_d;
  logic        skip_q, skip_d;
  h2sfp_pkg::setting_vec_t settings_q, settings_d;

  logic [24:0] pos_e;
  logic [23:0] len_e;
  logic [2:0]  mod_e;
  logic [47:0] shift_e;
  logic [2:0]  idx_e;
  logic        skip_e;
  logic [47:0] shift_n;
  logic [15:0] entry_id;
  logic [24:0] end_pos;

  always_comb begin
    // A frame start clears the frame state before the byte is taken in.
    pos_e   = start_i ? '0 : pos_q;
    len_e   = start_i ? '0 : len_q;
    mod_e   = start_i ? '0 : mod_q;
    shift_e = start_i ? '0 : shift_q;
    idx_e   = start_i ? '0 : idx_q;
    skip_e  = start_i ? 1'b0 : skip_q;

    pos_d      = pos_e;
    len_d      = len_e;
    mod_d      = mod_e;
    shift_d    = shift_e;
    idx_d      = idx_e;
    skip_d     = skip_e;
    settings_d = settings_q;
    res_o      = '{emit: 1'b0, status: h2sfp_pkg::StatusApplied};

    shift_n  = {shift_e[39:0], byte_i};
    entry_id = shift_n[47:32];
    end_pos  = 25'(len_e) + 25'(HdrLast);

    if (valid_i && !skip_e) begin
      pos_d = pos_e + 25'd1;
      if (pos_e < 25'(h2sfp_pkg::HdrBytes)) begin
        if (pos_e < 25'd3) begin
          len_d = {len_e[15:0], byte_i};
          // 256 is 4 modulo 6, so the residue follows the length byte by byte.
          mod_d = h2sfp_pkg::mod6(9'({mod_e, 2'b00}) + 9'(byte_i));
        end
        if (pos_e == 25'd4) begin
          if (byte_i[0]) begin
            res_o = '{emit: 1'b1, status: h2sfp_pkg::StatusAckIgnored};
          end else if (mod_e != 3'd0) begin
            res_o = '{emit: 1'b1, status: h2sfp_pkg::StatusBadLength};
          end
        end
        if (!res_o.emit && pos_e == 25'(HdrLast) && len_e == 24'd0) begin
          res_o = '{emit: 1'b1, status: h2sfp_pkg::StatusApplied};
        end
      end else begin
        if (idx_e == 3'(h2sfp_pkg::EntryBytes - 1)) begin
          if (entry_id >= 16'd1 && entry_id <= 16'(h2sfp_pkg::NumSettings)) begin
            settings_d[3'(entry_id - 16'd1)] = shift_n[31:0];
          end
          idx_d   = '0;
          shift_d = '0;
        end else begin
          idx_d   = idx_e + 3'd1;
          shift_d = shift_n;
        end
        if (pos_e == end_pos) begin
          res_o = '{emit: 1'b1, status: h2sfp_pkg::StatusApplied};
        end
      end
      if (res_o.emit) begin
        skip_d = 1'b1;
      end
    end
  end

  assign settings_o = settings_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      len_q      <= '0;
      mod_q      <= '0;
      shift_q    <= '0;
      idx_q      <= '0;
      skip_q     <= 1'b1;
      settings_q <= h2sfp_pkg::InitSettings;
    end else if (step_i) begin
      pos_q      <= pos_d;
      len_q      <= len_d;
      mod_q      <= mod_d;
      shift_q    <= shift_d;
      idx_q      <= idx_d;
      skip_q     <= skip_d;
      settings_q <= settings_d;
    end
  end

endmodule

// ===== rtl/http2_settings_frame_parser_top.sv =====
// A result is registered: the byte that completes it is held in the input register
// and parsed before the output register captures the result.
// Throughput: one frame byte per cycle; the input stalls only while a finished
// result waits in the output register and the next byte would produce another.
// Reset (asynchronous, active low) restores the protocol initial settings and
// leaves the parser idle until a byte marked as a frame start arrives.
module http2_settings_frame_parser_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  h2sfp_in_if.sink           req_i,
  h2sfp_out_if.source        rsp_o
);

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_start_q;
  logic       s1_adv;
  logic       step;

  logic                    out_valid_q;
  h2sfp_pkg::status_e      out_status_q;
  h2sfp_pkg::setting_vec_t out_settings_q;

  h2sfp_pkg::parse_res_t   res;
  h2sfp_pkg::setting_vec_t settings_next;

  h2sfp_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s1_valid_q),
    .step_i     (step),
    .byte_i     (s1_byte_q),
    .start_i    (s1_start_q),
    .res_o      (res),
    .settings_o (settings_next)
  );

  // A byte moves on unless it completes a frame while the last result is still held.
  assign s1_adv      = !res.emit || !out_valid_q || rsp_o.ready;
  assign step        = s1_valid_q && s1_adv;
  assign req_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        s1_valid_q <= 1'b1;
      end else if (step) begin
        s1_valid_q <= 1'b0;
      end
      if (step && res.emit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_byte_q  <= req_i.frame_byte;
      s1_start_q <= req_i.frame_start;
    end
    if (step && res.emit) begin
      out_status_q   <= res.status;
      out_settings_q <= settings_next;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.frame_status   = out_status_q;
  assign rsp_o.table_size     = out_settings_q[0];
  assign rsp_o.push_enable    = out_settings_q[1];
  assign rsp_o.stream_limit   = out_settings_q[2];
  assign rsp_o.window_size    = out_settings_q[3];
  assign rsp_o.frame_limit    = out_settings_q[4];
  assign rsp_o.hdr_list_limit = out_settings_q[5];

endmodule

// ===== rtl/h2sfp_check.sv =====
module h2sfp_check (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_status_i,
  input logic [31:0] out_first_i
);

  // The input only stalls behind a result that is being held back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> (out_valid_i && !out_ready_i))
    else $error("input stalled without a blocked result");

  // A fresh result must be preceded by an accepted byte that passed the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without a byte accepted two cycles before");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_status_i == h2sfp_pkg::StatusApplied ||
                     out_status_i == h2sfp_pkg::StatusAckIgnored ||
                     out_status_i == h2sfp_pkg::StatusBadLength))
    else $error("undefined frame status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_status_i) && $stable(out_first_i)))
    else $error("held result changed");

endmodule

bind http2_settings_frame_parser_top h2sfp_check u_h2sfp_check (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .out_status_i (rsp_o.frame_status),
  .out_first_i  (rsp_o.table_size)
);

// ===== test/tb.sv =====
module tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned FrameBytesGoal = 1500;

  typedef struct {
    logic [7:0] value;
    logic       start;
    bit         drain;
  } byte_req_t;

  typedef struct {
    h2sfp_pkg::status_e      status;
    h2sfp_pkg::setting_vec_t values;
  } settings_report_t;

  logic clk;
  logic rst_n;

  h2sfp_in_if  req_if ();
  h2sfp_out_if rsp_if ();

  http2_settings_frame_parser_top DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  byte_req_t        pending[$];
  settings_report_t reports_due[$];
  logic [7:0]       frame_buf[$];

  // Mirror of the parser state.
  h2sfp_pkg::setting_vec_t settings_now;
  logic [24:0]  parse_pos;
  logic [23:0]  payload_len;
  logic [47:0]  entry_bits;
  logic [2:0]   entry_cnt;
  bit           frame_done;

  bit          byte_taken = 1'b0;
  int unsigned bytes_in = 0;
  int unsigned cycles = 0;
  int unsigned errors = 0;
  bit          calm;

  // A stretch of the run with no idling on either side.
  assign calm = (bytes_in >= 600) && (bytes_in < 900);

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic post_report(input h2sfp_pkg::status_e status);
    settings_report_t r;
    r.status = status;
    r.values = settings_now;
    reports_due.push_back(r);
    frame_done = 1'b1;
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic start);
    logic [24:0] p;
    logic [15:0] id;
    if (start) begin
      parse_pos   = '0;
      payload_len = '0;
      entry_bits  = '0;
      entry_cnt   = '0;
      frame_done  = 1'b0;
    end
    if (!frame_done) begin
      p = parse_pos;
      parse_pos = parse_pos + 25'd1;
      if (p < h2sfp_pkg::HdrBytes) begin
        if (p < 3) payload_len = {payload_len[15:0], b};
        if (p == 4 && b[0]) begin
          post_report(h2sfp_pkg::StatusAckIgnored);
        end else if (p == 4 && (payload_len % h2sfp_pkg::EntryBytes) != 0) begin
          post_report(h2sfp_pkg::StatusBadLength);
        end else if (p == h2sfp_pkg::HdrBytes - 1 && payload_len == 0) begin
          post_report(h2sfp_pkg::StatusApplied);
        end
      end else begin
        entry_bits = {entry_bits[39:0], b};
        entry_cnt  = entry_cnt + 3'd1;
        if (entry_cnt >= h2sfp_pkg::EntryBytes) begin
          id = entry_bits[47:32];
          if (id >= 1 && id <= h2sfp_pkg::NumSettings) begin
            settings_now[id - 1] = entry_bits[31:0];
          end
          entry_cnt  = '0;
          entry_bits = '0;
        end
        if (32'(parse_pos) - h2sfp_pkg::HdrBytes == 32'(payload_len)) begin
          post_report(h2sfp_pkg::StatusApplied);
        end
      end
    end
  endtask

  task automatic hdr_to_buf(input logic [23:0] len, input logic [7:0] ftype,
                            input logic [7:0] flags, input logic [31:0] sid);
    frame_buf.delete();
    frame_buf.push_back(len[23:16]);
    frame_buf.push_back(len[15:8]);
    frame_buf.push_back(len[7:0]);
    frame_buf.push_back(ftype);
    frame_buf.push_back(flags);
    frame_buf.push_back(sid[31:24]);
    frame_buf.push_back(sid[23:16]);
    frame_buf.push_back(sid[15:8]);
    frame_buf.push_back(sid[7:0]);
  endtask

  task automatic entry_to_buf(input logic [15:0] id, input logic [31:0] val);
    frame_buf.push_back(id[15:8]);
    frame_buf.push_back(id[7:0]);
    frame_buf.push_back(val[31:24]);
    frame_buf.push_back(val[23:16]);
    frame_buf.push_back(val[15:8]);
    frame_buf.push_back(val[7:0]);
  endtask

  // Queues the first count bytes of the frame buffer as requests.
  task automatic send_frame(input int count, input bit drain);
    byte_req_t r;
    for (int i = 0; i < count; i++) begin
      r.value = frame_buf[i];
      r.start = (i == 0);
      r.drain = drain && (i == 0);
      pending.push_back(r);
    end
  endtask

  task automatic random_entries(input int n);
    logic [15:0] id;
    logic [31:0] val;
    int          r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(15);
      if (r < 10) id = 16'(1 + r % 6);
      else if (r == 10) id = 16'h0000;
      else if (r == 11) id = 16'hFFFF;
      else id = 16'($urandom_range(7, 65535));
      r = $urandom_range(7);
      if (r == 0) val = 32'h0;
      else if (r == 1) val = 32'hFFFF_FFFF;
      else val = $urandom;
      entry_to_buf(id, val);
    end
  endtask

  // Input driver: changes at the falling edge.
  always @(negedge clk) begin
    byte_req_t item;
    if (!rst_n) begin
      req_if.valid <= 1'b0;
      rsp_if.ready <= 1'b0;
    end else begin
      if (!req_if.valid || byte_taken) begin
        if (pending.size() > 0 && (calm || $urandom_range(99) >= 32) &&
            !(pending[0].drain && reports_due.size() > 0)) begin
          item = pending.pop_front();
          req_if.valid       <= 1'b1;
          req_if.frame_byte  <= item.value;
          req_if.frame_start <= item.start;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
      rsp_if.ready <= calm || ($urandom_range(99) >= 32);
    end
  end

  // Monitor: samples both channels at the rising edge.
  always @(posedge clk) begin
    settings_report_t        want;
    h2sfp_pkg::setting_vec_t got;
    byte_taken <= req_if.valid && req_if.ready;
    if (rst_n) begin
      if (req_if.valid && req_if.ready) begin
        absorb_byte(req_if.frame_byte, req_if.frame_start);
        bytes_in++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got = {rsp_if.hdr_list_limit, rsp_if.frame_limit,
               rsp_if.window_size, rsp_if.stream_limit,
               rsp_if.push_enable, rsp_if.table_size};
        if (reports_due.size() == 0) begin
          $display("%0t: report expected none, got status %0d", $time, rsp_if.frame_status);
          errors++;
        end else begin
          want = reports_due.pop_front();
          if (rsp_if.frame_status !== want.status) begin
            $display("%0t: frame_status expected %0d got %0d", $time, want.status,
                     rsp_if.frame_status);
            errors++;
          end
          for (int k = 0; k < h2sfp_pkg::NumSettings; k++) begin
            if (got[k] !== want.values[k]) begin
              $display("%0t: setting %0d expected %h got %h", $time, k + 1,
                       want.values[k], got[k]);
              errors++;
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    byte_req_t   r;
    int          kind;
    int          n;
    int          extra;
    int unsigned frame_bytes;
    logic [23:0] len;
    bit          first;
    bit          drain_now;

    req_if.valid       = 1'b0;
    req_if.frame_byte  = 8'h00;
    req_if.frame_start = 1'b0;
    rsp_if.ready       = 1'b0;
    rst_n              = 1'b0;

    settings_now = h2sfp_pkg::InitSettings;
    parse_pos    = '0;
    payload_len  = '0;
    entry_bits   = '0;
    entry_cnt    = '0;
    frame_done   = 1'b1;

    // A byte before any frame start is dropped.
    r.value = 8'hFF;
    r.start = 1'b0;
    r.drain = 1'b0;
    pending.push_back(r);
    // Ack frame, then one trailing byte that must be ignored.
    hdr_to_buf(24'd6, 8'h04, 8'h01, 32'h0);
    frame_buf[5] = 8'hFF;
    send_frame(6, 1'b0);
    // Largest length, not a multiple of six, every flag but ack set.
    hdr_to_buf(24'hFF_FFFF, 8'hFF, 8'hFE, 32'h0);
    send_frame(5, 1'b0);
    // One entry for the highest identifier with a zero value.
    hdr_to_buf(24'd6, 8'h04, 8'h00, 32'h0);
    entry_to_buf(16'd6, 32'h0);
    send_frame(frame_buf.size(), 1'b0);

    frame_bytes = 0;
    first = 1'b1;
    while (frame_bytes < FrameBytesGoal) begin
      kind = $urandom_range(99);
      drain_now = first || ($urandom_range(29) == 0);
      first = 1'b0;
      if (kind < 55) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
        hdr_to_buf(24'(6 * n), ($urandom_range(7) == 0) ? 8'($urandom) : 8'h04,
                   8'($urandom) & 8'hFE, $urandom);
        random_entries(n);
        frame_bytes += frame_buf.size();
        send_frame(frame_buf.size(), drain_now);
      end else if (kind < 65) begin
        len = $urandom_range(1) ? 24'($urandom) : 24'(6 * $urandom_range(0, 4));
        hdr_to_buf(len, 8'h04, 8'($urandom) | 8'h01, $urandom);
        extra = $urandom_range(0, 8);
        for (int i = 0; i < extra; i++) frame_buf.push_back(8'($urandom));
        frame_bytes += frame_buf.size();
        send_frame(frame_buf.size(), drain_now);
      end else if (kind < 75) begin
        len = $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(1, 40));
        if (len % 6 == 0) len = len + 24'd1;
        hdr_to_buf(len, 8'h04, 8'($urandom) & 8'hFE, $urandom);
        extra = $urandom_range(0, 8);
        for (int i = 0; i < extra; i++) frame_buf.push_back(8'($urandom));
        frame_bytes += frame_buf.size();
        send_frame(frame_buf.size(), drain_now);
      end else if (kind < 88) begin
        // Frame cut short and abandoned by the next frame start.
        n = $urandom_range(0, 3);
        if ($urandom_range(3) == 0) len = 24'(6 * $urandom_range(1, 2796202));
        else len = 24'(6 * (n + $urandom_range(1, 3)));
        hdr_to_buf(len, 8'h04, 8'($urandom) & 8'hFE, $urandom);
        random_entries(n);
        extra = $urandom_range(1, frame_buf.size());
        frame_bytes += extra;
        send_frame(extra, drain_now);
      end else begin
        extra = $urandom_range(1, 6);
        for (int i = 0; i < extra; i++) begin
          r.value = 8'($urandom);
          r.start = ($urandom_range(7) == 0);
          r.drain = 1'b0;
          pending.push_back(r);
        end
        frame_bytes += extra;
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    do @(posedge clk); while (pending.size() > 0 || req_if.valid || reports_due.size() > 0);
    repeat (20) @(posedge clk);

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
